// ===== hdl/stfl_pkg.sv =====
// ----------------------------------------------------------------------------
// stfl_pkg
// Shared types and constants of the sorted table floor lookup unit.
// ----------------------------------------------------------------------------
package stfl_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int ADDR_W      = 32;
	localparam int ID_W        = 16;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	// operation codes carried on the input tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// one table entry, address in the low bits
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	// table memory access: one write port and one read port per cycle
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic              table_full;
		logic              found;
		logic [ID_W-1:0]   result_id;
		logic [ADDR_W-1:0] base_address;
	} res_t;

endpackage

// ===== hdl/stfl_table_ram.sv =====
// ----------------------------------------------------------------------------
// stfl_table_ram
// Simple dual port table memory, registered read data, no reset.
// ----------------------------------------------------------------------------
module stfl_table_ram (
	input  logic              clk,
	input  stfl_pkg::mem_req_t req,
	output stfl_pkg::entry_t  rd_data
);

	stfl_pkg::entry_t mem_q [stfl_pkg::TABLE_DEPTH];
	stfl_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_q <= mem_q[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/stfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// stfl_ctrl
// Sequencer: binary search, insert shift and result build over the table.
// ----------------------------------------------------------------------------
module stfl_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_op,
	input  logic [stfl_pkg::ADDR_W-1:0]  in_address,
	input  logic [stfl_pkg::ID_W-1:0]    in_entry_id,
	output logic                         res_valid,
	input  logic                         res_ready,
	output stfl_pkg::res_t               res,
	output stfl_pkg::mem_req_t           mem_req,
	input  stfl_pkg::entry_t             rd_data
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_SRCH_RD  = 8'b0000_0010,
		ST_SRCH_CMP = 8'b0000_0100,
		ST_SHIFT    = 8'b0000_1000,
		ST_WRITE    = 8'b0001_0000,
		ST_FETCH    = 8'b0010_0000,
		ST_RESP     = 8'b0100_0000,
		ST_SPARE    = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	logic [stfl_pkg::CNT_W-1:0]      cnt_q;
	logic [stfl_pkg::CNT_W-1:0]      lo_q;
	logic [stfl_pkg::CNT_W-1:0]      hi_q;
	logic [stfl_pkg::CNT_W-1:0]      mid_q;
	logic [stfl_pkg::CNT_W-1:0]      idx_q;
	logic [stfl_pkg::CNT_W-1:0]      widx_q;
	logic                            pend_q;
	logic                            op_q;
	logic [stfl_pkg::ADDR_W-1:0]     key_q;
	logic [stfl_pkg::ID_W-1:0]       id_q;
	stfl_pkg::res_t                  res_q;
	logic [stfl_pkg::CNT_W-1:0]      mid;
	logic [stfl_pkg::CNT_W-1:0]      lo_m1;
	logic [stfl_pkg::CNT_W-1:0]      idx_m1;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_m1  = lo_q - 1'b1;
	assign idx_m1 = idx_q - 1'b1;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res       = res_q;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_SRCH_RD: begin
				if (lo_q < hi_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = mid[stfl_pkg::IDX_W-1:0];
				end else if (op_q == stfl_pkg::OP_LOOKUP && lo_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = lo_m1[stfl_pkg::IDX_W-1:0];
				end
			end
			ST_SHIFT: begin
				// write the entry read last cycle one slot up, read the next one
				mem_req.we    = pend_q;
				mem_req.waddr = widx_q[stfl_pkg::IDX_W-1:0];
				mem_req.wdata = rd_data;
				if (idx_q > lo_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = idx_m1[stfl_pkg::IDX_W-1:0];
				end
			end
			ST_WRITE: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = lo_q[stfl_pkg::IDX_W-1:0];
				mem_req.wdata.addr = key_q;
				mem_req.wdata.id   = id_q;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			idx_q   <= '0;
			widx_q  <= '0;
			pend_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_op == stfl_pkg::OP_INSERT && cnt_q == stfl_pkg::DEPTH_CNT) begin
							res_q   <= '{table_full: 1'b1, found: 1'b0,
								result_id: '0, base_address: '0};
							state_q <= ST_RESP;
						end else begin
							lo_q    <= '0;
							hi_q    <= cnt_q;
							state_q <= ST_SRCH_RD;
						end
					end
				end
				ST_SRCH_RD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_SRCH_CMP;
					end else if (op_q == stfl_pkg::OP_INSERT) begin
						idx_q   <= cnt_q;
						pend_q  <= 1'b0;
						state_q <= ST_SHIFT;
					end else if (lo_q == '0) begin
						res_q   <= '0;
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_SRCH_CMP: begin
					if (rd_data.addr <= key_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= ST_SRCH_RD;
				end
				ST_SHIFT: begin
					if (idx_q > lo_q) begin
						pend_q <= 1'b1;
						widx_q <= idx_q;
						idx_q  <= idx_m1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					cnt_q   <= cnt_q + 1'b1;
					res_q   <= '0;
					state_q <= ST_RESP;
				end
				ST_FETCH: begin
					res_q.table_full   <= 1'b0;
					res_q.found        <= 1'b1;
					res_q.base_address <= rd_data.addr;
					res_q.result_id    <= rd_data.id;
					state_q            <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields held for the whole operation
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= in_op;
			key_q <= in_address;
			id_q  <= in_entry_id;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= stfl_pkg::DEPTH_CNT)
		else $error("entry count above table depth");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH_CMP |=> lo_q <= hi_q && hi_q <= cnt_q)
		else $error("search window out of order");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
		else $error("shift reads the entry it writes");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> cnt_q < stfl_pkg::DEPTH_CNT && op_q == stfl_pkg::OP_INSERT)
		else $error("insert write into a full table");
`endif

endmodule

// ===== hdl/sorted_table_floor_lookup_unit.sv =====
// Lookup: binary search over the table memory, each step a read and then a compare,
// then the entry just below the final position is read back as the result.
// Insert: the same search, then the entries from the position up move one slot up
// through the single read port before the new entry is written; a full table drops it.
// One item at a time; the output register frees the core while a result waits.
// Reset clears the entry count and control state; the table memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_table_floor_lookup_unit
// Sorted (address, id) table with insert and greatest-not-above lookup.
// ----------------------------------------------------------------------------
module sorted_table_floor_lookup_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [31:0] address, [47:32] entry_id
	input  logic        s_axis_tuser,  // op: 0 insert, 1 lookup
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [31:0] base_address, [47:32] result_id
	output logic [1:0]  m_axis_tuser   // [0] found, [1] table_full
);

	stfl_pkg::mem_req_t mem_req;
	stfl_pkg::entry_t   rd_data;
	stfl_pkg::res_t     res;
	logic               res_valid;
	logic               res_ready;

	// output register state
	logic               out_valid_q;
	stfl_pkg::res_t     out_q;

	stfl_table_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	stfl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_op       (s_axis_tuser),
		.in_address  (s_axis_tdata[31:0]),
		.in_entry_id (s_axis_tdata[47:32]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_req     (mem_req),
		.rd_data     (rd_data)
	);

	// the result register takes a new result whenever it is empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload holds while a transfer is stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.result_id, out_q.base_address};
	assign m_axis_tuser  = {out_q.table_full, out_q.found};

`ifndef SYNTHESIS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("result both found and full");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("not-found result carries data");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_axis_tready)
		else $error("input taken while a result is pending in the core");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted table floor lookup unit. A table model
// kept in queues predicts every result; results are checked in order, field by
// field. Covers empty-table lookups, field extremes, equal addresses, a random
// insert/lookup mix, filling the table and dropped inserts once it is full.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_ITEMS = 700;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tuser = stfl_pkg::OP_INSERT;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	sorted_table_floor_lookup_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// sorted table model and pending results
	logic [stfl_pkg::ADDR_W-1:0] table_addr[$];
	logic [stfl_pkg::ID_W-1:0]   table_id[$];
	stfl_pkg::res_t              pending_results[$];
	logic [stfl_pkg::ADDR_W-1:0] addr_pool[16];

	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left = 0;

	// index of the first stored entry whose address is above key
	function automatic int first_above_idx(logic [stfl_pkg::ADDR_W-1:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = table_addr.size();
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (table_addr[mid] <= key)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	task automatic model_table_op(logic op, logic [stfl_pkg::ADDR_W-1:0] addr,
		logic [stfl_pkg::ID_W-1:0] id);
		stfl_pkg::res_t r;
		int pos;
		r = '0;
		pos = first_above_idx(addr);
		if (op == stfl_pkg::OP_INSERT) begin
			if (table_addr.size() >= stfl_pkg::TABLE_DEPTH) begin
				r.table_full = 1'b1;
			end else begin
				table_addr.insert(pos, addr);
				table_id.insert(pos, id);
			end
		end else if (pos > 0) begin
			r.found = 1'b1;
			r.base_address = table_addr[pos - 1];
			r.result_id = table_id[pos - 1];
		end
		pending_results.insert(pending_results.size(), r);
	endtask

	// one transfer on the input side, with bursts and random gaps
	task automatic send_item(logic op, logic [stfl_pkg::ADDR_W-1:0] addr,
		logic [stfl_pkg::ID_W-1:0] id);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {id, addr};
		do @(posedge clk); while (!s_axis_tready);
		model_table_op(op, addr, id);
	endtask

	// hold off the sender until every pending result has come out
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic [stfl_pkg::ADDR_W-1:0] rand_addr();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return addr_pool[$urandom_range(0, 15)];
			default: return stfl_pkg::ADDR_W'($urandom());
		endcase
	endfunction

	// query aimed at, just below or just above a stored address, or a random address
	function automatic logic [stfl_pkg::ADDR_W-1:0] rand_query();
		logic [stfl_pkg::ADDR_W-1:0] a;
		if (table_addr.size() == 0 || $urandom_range(0, 3) == 0)
			return rand_addr();
		a = table_addr[$urandom_range(0, table_addr.size() - 1)];
		case ($urandom_range(0, 2))
			0:       return a - 1;
			1:       return a;
			default: return a + 1;
		endcase
	endfunction

	task automatic test_empty_table();
		send_item(stfl_pkg::OP_LOOKUP, '0, '0);
		send_item(stfl_pkg::OP_LOOKUP, '1, '1);
		send_item(stfl_pkg::OP_LOOKUP, 32'h8000_0000, 16'h5A5A);
	endtask

	task automatic test_directed();
		send_item(stfl_pkg::OP_INSERT, 32'h0000_1000, 16'h1111);
		// below every stored entry
		send_item(stfl_pkg::OP_LOOKUP, 32'h0000_0FFF, '0);
		send_item(stfl_pkg::OP_LOOKUP, '0, '1);
		// equal address, later insert must win
		send_item(stfl_pkg::OP_INSERT, 32'h0000_1000, 16'h2222);
		send_item(stfl_pkg::OP_LOOKUP, 32'h0000_1000, '0);
		send_item(stfl_pkg::OP_LOOKUP, 32'h0000_1001, '0);
		send_item(stfl_pkg::OP_INSERT, '1, '1);
		send_item(stfl_pkg::OP_INSERT, '0, '0);
		send_item(stfl_pkg::OP_LOOKUP, '0, '0);
		send_item(stfl_pkg::OP_LOOKUP, 32'h0000_0FFF, '0);
		send_item(stfl_pkg::OP_LOOKUP, 32'hFFFF_FFFE, '0);
		send_item(stfl_pkg::OP_LOOKUP, '1, '0);
		send_item(stfl_pkg::OP_INSERT, '0, 16'hABCD);
		send_item(stfl_pkg::OP_LOOKUP, '0, '0);
		send_item(stfl_pkg::OP_INSERT, 32'h5555_5555, 16'h5555);
		send_item(stfl_pkg::OP_INSERT, 32'hAAAA_AAAA, 16'hAAAA);
		send_item(stfl_pkg::OP_LOOKUP, 32'h7FFF_FFFF, '0);
		send_item(stfl_pkg::OP_LOOKUP, 32'hBFFF_FFFF, '0);
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 16; i++)
			addr_pool[i] = stfl_pkg::ADDR_W'($urandom());
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_drain();
			if ($urandom_range(0, 9) < 4)
				send_item(stfl_pkg::OP_INSERT, rand_addr(), stfl_pkg::ID_W'($urandom()));
			else
				send_item(stfl_pkg::OP_LOOKUP, rand_query(), stfl_pkg::ID_W'($urandom()));
		end
	endtask

	// appending at the top address keeps every insert cheap
	task automatic test_fill_table();
		while (table_addr.size() < stfl_pkg::TABLE_DEPTH) begin
			send_item(stfl_pkg::OP_INSERT, '1, stfl_pkg::ID_W'(table_addr.size()));
			if ($urandom_range(0, 63) == 0)
				send_item(stfl_pkg::OP_LOOKUP, rand_query(), stfl_pkg::ID_W'($urandom()));
		end
	endtask

	task automatic test_full_table();
		send_item(stfl_pkg::OP_INSERT, '0, '0);
		send_item(stfl_pkg::OP_INSERT, '1, '1);
		send_item(stfl_pkg::OP_LOOKUP, '1, '0);
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 1) == 0)
				send_item(stfl_pkg::OP_INSERT, rand_addr(), stfl_pkg::ID_W'($urandom()));
			else
				send_item(stfl_pkg::OP_LOOKUP, rand_query(), stfl_pkg::ID_W'($urandom()));
		end
	endtask

	// receiver stall pattern, switching at random among four modes
	int stall_mode = 0;
	int stall_cnt = 0;
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt % 200 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
			2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((stall_cnt % 8) < 5);
		endcase
	end

	stfl_pkg::res_t want;
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser[0] !== want.found) begin
					$error("found: expected %b, got %b", want.found, m_axis_tuser[0]);
					mismatch_count++;
				end
				if (m_axis_tuser[1] !== want.table_full) begin
					$error("table_full: expected %b, got %b", want.table_full,
						m_axis_tuser[1]);
					mismatch_count++;
				end
				if (m_axis_tdata[31:0] !== want.base_address) begin
					$error("base_address: expected %h, got %h", want.base_address,
						m_axis_tdata[31:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[47:32] !== want.result_id) begin
					$error("result_id: expected %h, got %h", want.result_id,
						m_axis_tdata[47:32]);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed();
		test_random_mix();
		test_fill_table();
		test_full_table();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
